[sv/esc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and small helpers for the epoch to calendar block.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam logic [31:0] DAY_SECS   = 32'd86400;
    localparam logic [31:0] HOUR_SECS  = 32'd3600;
    localparam logic [31:0] MIN_SECS   = 32'd60;
    localparam logic [31:0] YEAR_DAYS  = 32'd365;
    localparam logic [31:0] LEAP_DAYS  = 32'd366;
    localparam logic [11:0] EPOCH_YEAR = 12'd1970;
    localparam logic [2:0]  EPOCH_WDAY = 3'd4;     // 1970-01-01 was a Thursday
    localparam logic [3:0]  DAY_BITS_LAST  = 4'd15;
    localparam logic [3:0]  HOUR_BITS_LAST = 4'd4;
    localparam logic [3:0]  MIN_BITS_LAST  = 4'd5;
    localparam logic [3:0]  MONTH_FEB = 4'd1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DAYS   = 7'b0000010,
        S_HOURS  = 7'b0000100,
        S_MINS   = 7'b0001000,
        S_YEARS  = 7'b0010000,
        S_MONTHS = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    // Years reachable are 1970..2106; the only century year that is not
    // leap in that span is 2100.
    function automatic logic f_leap(input logic [11:0] year);
        f_leap = (year[1:0] == 2'b00) && (year != 12'd2100);
    endfunction

    function automatic logic [4:0] f_month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd0:  len = 5'd31;
            4'd1:  len = leap ? 5'd29 : 5'd28;
            4'd2:  len = 5'd31;
            4'd3:  len = 5'd30;
            4'd4:  len = 5'd31;
            4'd5:  len = 5'd30;
            4'd6:  len = 5'd31;
            4'd7:  len = 5'd31;
            4'd8:  len = 5'd30;
            4'd9:  len = 5'd31;
            4'd10: len = 5'd30;
            4'd11: len = 5'd31;
            default: len = 5'd31;
        endcase
        f_month_len = len;
    endfunction

    // Reduce a small value (at most 41) modulo 7.
    function automatic logic [2:0] f_mod7(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        for (int k = 0; k < 5; k++) begin
            if (t >= 6'd7) begin
                t = t - 6'd7;
            end
        end
        f_mod7 = t[2:0];
    endfunction

endpackage

[sv/epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Seconds since 1970-01-01 to Gregorian date, time of day and weekday.
// The conversion is iterative: one 33-bit subtractor does 16 + 5 + 6 division
// steps, up to 137 year steps and up to 12 month steps. One beat in flight;
// o_ready is high only when idle, so a new beat is taken in the cycle after
// the result loads.
// Reset (synchronous, active low) returns to idle with no output pending.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_seconds_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [2:0]  o_weekday_out
);

    t_state      r_state, n_state;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_days, n_days;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [11:0] r_year, n_year;
    logic [3:0]  r_mon, n_mon;
    logic [2:0]  r_wd, n_wd;
    logic        r_out_valid, n_out_valid;
    logic [11:0] r_year_out;
    logic [3:0]  r_month_out;
    logic [4:0]  r_day_out;
    logic [4:0]  r_hour_out;
    logic [5:0]  r_minute_out;
    logic [5:0]  r_second_out;
    logic [2:0]  r_weekday_out;

    logic [31:0] w_sub_b;
    logic [32:0] w_diff;
    logic        w_ge;
    logic        w_leap;
    logic [4:0]  w_mlen;
    logic [31:0] w_rem;
    logic        w_load;

    assign w_leap = f_leap(r_year);
    assign w_mlen = f_month_len(r_mon, w_leap && (r_mon == MONTH_FEB));

    // shared compare/subtract unit
    always_comb begin
        case (r_state)
            S_DAYS:   w_sub_b = DAY_SECS << r_cnt;
            S_HOURS:  w_sub_b = HOUR_SECS << r_cnt;
            S_MINS:   w_sub_b = MIN_SECS << r_cnt;
            S_YEARS:  w_sub_b = w_leap ? LEAP_DAYS : YEAR_DAYS;
            S_MONTHS: w_sub_b = {27'd0, w_mlen};
            default:  w_sub_b = 32'd0;
        endcase
    end

    assign w_diff = {1'b0, r_acc} - {1'b0, w_sub_b};
    assign w_ge   = ~w_diff[32];
    assign w_rem  = w_ge ? w_diff[31:0] : r_acc;

    assign o_ready = (r_state == S_IDLE);
    assign w_load  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_days  = r_days;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_year  = r_year;
        n_mon   = r_mon;
        n_wd    = r_wd;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_acc   = i_seconds_count;
                    n_cnt   = DAY_BITS_LAST;
                    n_state = S_DAYS;
                end
            end
            S_DAYS: begin
                n_acc  = w_rem;
                n_days = {r_days[14:0], w_ge};
                n_cnt  = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_cnt   = HOUR_BITS_LAST;
                    n_state = S_HOURS;
                end
            end
            S_HOURS: begin
                n_acc  = w_rem;
                n_hour = {r_hour[3:0], w_ge};
                n_cnt  = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_cnt   = MIN_BITS_LAST;
                    n_state = S_MINS;
                end
            end
            S_MINS: begin
                n_acc = w_rem;
                n_min = {r_min[4:0], w_ge};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_sec   = w_rem[5:0];
                    n_acc   = {16'd0, r_days};
                    n_year  = EPOCH_YEAR;
                    n_mon   = 4'd0;
                    n_wd    = EPOCH_WDAY;
                    n_state = S_YEARS;
                end
            end
            S_YEARS: begin
                if (w_ge) begin
                    n_acc  = w_diff[31:0];
                    n_year = r_year + 12'd1;
                    n_wd   = f_mod7({3'd0, r_wd} + (w_leap ? 6'd2 : 6'd1));
                end else begin
                    n_state = S_MONTHS;
                end
            end
            S_MONTHS: begin
                if (w_ge) begin
                    n_acc = w_diff[31:0];
                    n_mon = r_mon + 4'd1;
                    n_wd  = f_mod7({3'd0, r_wd} + {1'b0, w_mlen - 5'd28});
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_year <= n_year;
        r_mon  <= n_mon;
        r_wd   <= n_wd;
        if (w_load) begin
            r_year_out    <= r_year;
            r_month_out   <= r_mon + 4'd1;
            r_day_out     <= r_acc[4:0] + 5'd1;
            r_hour_out    <= r_hour;
            r_minute_out  <= r_min;
            r_second_out  <= r_sec;
            r_weekday_out <= f_mod7({3'd0, r_wd} + {1'b0, r_acc[4:0]});
        end
    end

    assign o_valid       = r_out_valid;
    assign o_year_out    = r_year_out;
    assign o_month_out   = r_month_out;
    assign o_day_out     = r_day_out;
    assign o_hour_out    = r_hour_out;
    assign o_minute_out  = r_minute_out;
    assign o_second_out  = r_second_out;
    assign o_weekday_out = r_weekday_out;

endmodule

[sv/esc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks for the epoch to calendar block, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker import esc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_seconds_count,
    input logic        o_valid,
    input logic        i_ready,
    input logic [11:0] o_year_out,
    input logic [3:0]  o_month_out,
    input logic [4:0]  o_day_out,
    input logic [4:0]  o_hour_out,
    input logic [5:0]  o_minute_out,
    input logic [5:0]  o_second_out,
    input logic [2:0]  o_weekday_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_year_out) && $stable(o_day_out))
        else $error("output beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready still high after input beat");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_out >= 4'd1) && (o_month_out <= 4'd12) && (o_day_out >= 5'd1)
            && (o_hour_out <= 5'd23) && (o_minute_out <= 6'd59) && (o_second_out <= 6'd59)
            && (o_weekday_out <= 3'd6) && (o_year_out >= 12'd1970) && (o_year_out <= 12'd2106))
        else $error("output field out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not return block to idle");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks epoch_seconds_to_calendar: 32-bit epoch seconds in, Gregorian date,
// time of day and weekday out. A table of directed stamps is sent first,
// then random stamps, many aimed at year and month edges. Each result beat is
// compared field by field with a calendar predictor. Both handshake sides
// idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned N_RANDOM  = 1133;
    localparam int unsigned LONG_HOLD = 600;
    localparam int unsigned TAIL_WAIT = 200;
    localparam int unsigned SECS_DAY  = 86400;
    localparam logic [2:0]  SUNDAY    = 3'd0;
    localparam logic [2:0]  THURSDAY  = 3'd4;
    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } cal_t;

    typedef struct {
        logic [31:0] secs;
        bit          typed;
        cal_t        want;
    } stamp_row_t;

    typedef struct {
        logic [31:0] secs;
        cal_t        date;
    } pending_t;

    localparam int N_DIRECTED = 17;
    stamp_row_t directed_stamps [N_DIRECTED] = '{
        '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, THURSDAY}},
        '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, SUNDAY}},
        '{32'd86399,      1'b0, '0},
        '{32'd86400,      1'b0, '0},
        '{32'd31535999,   1'b0, '0},
        '{32'd31536000,   1'b0, '0},
        '{32'd68169600,   1'b0, '0},
        '{32'd94694399,   1'b0, '0},
        '{32'd94694400,   1'b0, '0},
        '{32'd951782400,  1'b0, '0},
        '{32'd4102444800, 1'b0, '0},
        '{32'd4107542399, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'h7FFF_FFFF,  1'b0, '0},
        '{32'h8000_0000,  1'b0, '0},
        '{32'h5555_5555,  1'b0, '0},
        '{32'hAAAA_AAAA,  1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_seconds_count = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [11:0] o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_day_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;
    logic [2:0]  o_weekday_out;

    pending_t    pending_dates [$];
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned hold_token = 0;
    bit          steady = 1'b0;

    epoch_seconds_to_calendar dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_seconds_count (i_seconds_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_year_out      (o_year_out),
        .o_month_out     (o_month_out),
        .o_day_out       (o_day_out),
        .o_hour_out      (o_hour_out),
        .o_minute_out    (o_minute_out),
        .o_second_out    (o_second_out),
        .o_weekday_out   (o_weekday_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_len(input int unsigned y, input int unsigned m);
        if (m == 2 && is_leap(y)) begin
            return 29;
        end
        return MONTH_LEN[m - 1];
    endfunction

    function automatic int unsigned year_len(input int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    // Calendar predictor: walk years, then months, then weekday by Larsen.
    function automatic cal_t calendar_of(input logic [31:0] secs);
        int unsigned s, days, tod, y, m, yy, mm, d, wd;
        cal_t c;
        s    = secs;
        days = s / SECS_DAY;
        tod  = s % SECS_DAY;
        y    = 1970;
        while (days >= year_len(y)) begin
            days -= year_len(y);
            y++;
        end
        m = 1;
        while (days >= month_len(y, m)) begin
            days -= month_len(y, m);
            m++;
        end
        d  = days + 1;
        yy = y;
        mm = m;
        if (mm < 3) begin
            mm += 12;
            yy -= 1;
        end
        wd = (d + 1 + 2 * mm + (3 * (mm + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400) % 7;
        c.year    = 12'(y);
        c.month   = 4'(m);
        c.day     = 5'(d);
        c.hour    = 5'(tod / 3600);
        c.minute  = 6'((tod % 3600) / 60);
        c.second  = 6'(tod % 60);
        c.weekday = 3'(wd);
        return c;
    endfunction

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Random stamp: fully random, near the 32-bit top, or a date in a month, often its first/last day or a day edge.
    function automatic logic [31:0] next_stamp();
        int unsigned kind, y, m, len, k;
        longint unsigned d, s;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            return $urandom();
        end
        if (kind < 42) begin
            return 32'hFFFF_FFFF - $urandom_range(0, SECS_DAY * 500);
        end
        y = $urandom_range(1970, 2106);
        m = (y == 2106) ? $urandom_range(1, 2) : $urandom_range(1, 12);
        d = 0;
        for (k = 1970; k < y; k++) begin
            d += year_len(k);
        end
        for (k = 1; k < m; k++) begin
            d += month_len(y, k);
        end
        len = month_len(y, m);
        case ($urandom_range(0, 2))
            0: d += 0;
            1: d += len - 1;
            default: d += $urandom_range(0, len - 1);
        endcase
        s = d * SECS_DAY;
        case ($urandom_range(0, 2))
            0: s += 0;
            1: s += SECS_DAY - 1;
            default: s += $urandom_range(0, SECS_DAY - 1);
        endcase
        if (s > 64'hFFFF_FFFF) begin
            s = 64'hFFFF_FFFF - $urandom_range(0, SECS_DAY - 1);
        end
        return s[31:0];
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] secs,
                               input int unsigned got, input int unsigned want);
        if (got != want) begin
            report($sformatf("stamp 0x%08h %s got %0d expected %0d", secs, name, got, want));
        end
    endtask

    task automatic check_result();
        pending_t p;
        if (pending_dates.size() == 0) begin
            report("result beat with no date pending");
        end else begin
            p = pending_dates.pop_front();
            check_field("year",    p.secs, o_year_out,    p.date.year);
            check_field("month",   p.secs, o_month_out,   p.date.month);
            check_field("day",     p.secs, o_day_out,     p.date.day);
            check_field("hour",    p.secs, o_hour_out,    p.date.hour);
            check_field("minute",  p.secs, o_minute_out,  p.date.minute);
            check_field("second",  p.secs, o_second_out,  p.date.second);
            check_field("weekday", p.secs, o_weekday_out, p.date.weekday);
            n_checked++;
        end
    endtask

    // Offer one beat, hold until accepted, then idle or drain as asked.
    task automatic send_stamp(input logic [31:0] secs, input cal_t want,
                              input int unsigned gap, input bit drain);
        pending_t p;
        i_valid         <= 1'b1;
        i_seconds_count <= secs;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        p.secs = secs;
        p.date = want;
        pending_dates.push_back(p);
        n_sent++;
        if (drain || gap > 0) begin
            i_valid <= 1'b0;
            while (drain && pending_dates.size() != 0) begin
                @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result side: check beats, drive i_ready with random and long stalls.
    initial begin
        int unsigned stall_left;
        int unsigned holds_seen;
        stall_left = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                check_result();
            end
            if (hold_token != holds_seen) begin
                holds_seen = hold_token;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                stall_left = idle_len() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned i, gap;
        logic [31:0] secs;
        cal_t want;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            secs = directed_stamps[i].secs;
            want = directed_stamps[i].typed ? directed_stamps[i].want : calendar_of(secs);
            gap  = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
            send_stamp(secs, want, gap, 1'b0);
        end

        for (i = 0; i < N_RANDOM; i++) begin
            steady = (i >= 200 && i < 330);
            if (i == 500) begin
                hold_token++;
            end
            secs = next_stamp();
            gap  = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
            send_stamp(secs, calendar_of(secs), gap,
                       (i == 800 || i == N_RANDOM - 1));
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("%0d stamps sent, %0d dates checked, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("covered epoch start, 32-bit top, leap days, year 2100, month and day edges");
        if (n_errors == 0 && pending_dates.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (pending_dates.size() != 0) begin
                $display("%0d dates never returned", pending_dates.size());
            end
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout: %0d stamps sent, %0d dates checked", n_sent, n_checked);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
sv/esc_pkg.sv
sv/epoch_seconds_to_calendar.sv
sv/esc_checker.sv
tb/testbench.sv
